### hdl/hex_record_char_parser_macros.svh
// assertion helpers used by the parser decode module
`ifndef HEX_RECORD_CHAR_PARSER_MACROS_SVH
`define HEX_RECORD_CHAR_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HRCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define HRCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hrcp_pkg.sv
`default_nettype none

package hrcp_pkg;

  // ring of result slots
  localparam int RING_DEPTH = 32;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // ascii characters of interest
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  // character positions inside a record
  localparam logic [15:0] POS_LEN_HI   = 16'd1;
  localparam logic [15:0] POS_LEN_LO   = 16'd2;
  localparam logic [15:0] POS_ADDR_3   = 16'd3;
  localparam logic [15:0] POS_ADDR_2   = 16'd4;
  localparam logic [15:0] POS_ADDR_1   = 16'd5;
  localparam logic [15:0] POS_ADDR_0   = 16'd6;
  localparam logic [15:0] POS_TYPE_END = 16'd8;
  localparam logic [15:0] REC_END_BASE = 16'd9;

  // digit phase of a data word, from position bits [1:0]
  localparam logic [1:0] PH_LOW_HI  = 2'd1;
  localparam logic [1:0] PH_LOW_LO  = 2'd2;
  localparam logic [1:0] PH_HIGH_HI = 2'd3;
  localparam logic [1:0] PH_HIGH_LO = 2'd0;

  typedef enum logic [1:0] {
    KIND_LENGTH  = 2'd0,
    KIND_ADDRESS = 2'd1,
    KIND_DATA    = 2'd2
  } word_kind_t;

  // one decoded word on its way to the output register
  typedef struct packed {
    logic        valid;
    logic [4:0]  slot;
    logic [15:0] value;
    word_kind_t  kind;
  } res_t;

endpackage

`default_nettype wire

### hdl/hrcp_in_stage.sv
`default_nettype none

module hrcp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_char
  input  wire logic       advance,
  output logic            item_valid,
  output logic [7:0]      item_char
);
  import hrcp_pkg::*;

  logic       valid_r;
  logic [7:0] char_r;

  // room when empty or when the held item moves on this cycle
  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item_char  = char_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

### hdl/hrcp_decode.sv
`default_nettype none
`include "hex_record_char_parser_macros.svh"

module hrcp_decode (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_char,
  input  wire logic       out_free,
  output logic            advance,
  output hrcp_pkg::res_t  res
);
  import hrcp_pkg::*;

  logic [15:0]       pos_r, pos_nxt;
  logic [15:0]       end_r, end_nxt;
  logic [15:0]       low_r, low_nxt;
  logic [15:0]       high_r, high_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic        is_colon;
  logic [7:0]  digit;
  logic [15:0] pos;
  logic [15:0] dig_lo;
  logic [15:0] dig_hi;
  logic [15:0] low_sum;
  logic [15:0] high_sum;

  assign advance = item_valid && out_free;

  // character to digit, colon restarts the record
  always_comb begin
    is_colon = (item_char == CHAR_COLON);
    if (is_colon) begin
      digit = 8'h00;
    end else if (item_char <= CHAR_NINE) begin
      digit = item_char - CHAR_ZERO;
    end else begin
      digit = item_char - CHAR_SEVEN;
    end
    pos      = is_colon ? 16'h0000 : pos_r;
    dig_lo   = {8'h00, digit};
    dig_hi   = {4'h0, digit, 4'h0};
    low_sum  = low_r + dig_lo;
    high_sum = high_r + dig_lo;
  end

  // field assembly by position
  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    end_nxt   = end_r;
    res.valid = 1'b0;
    res.value = low_sum;
    res.kind  = KIND_LENGTH;
    res.slot  = 5'(slot_r);

    case (pos)
      POS_LEN_HI: begin
        low_nxt = dig_hi;
      end
      POS_LEN_LO: begin
        low_nxt   = low_sum;
        end_nxt   = REC_END_BASE + {low_sum[14:0], 1'b0};
        res.valid = 1'b1;
        res.value = low_sum;
        res.kind  = KIND_LENGTH;
      end
      POS_ADDR_3: begin
        low_nxt = dig_hi;
      end
      POS_ADDR_2: begin
        low_nxt = {low_sum[7:0], 8'h00};
      end
      POS_ADDR_1: begin
        low_nxt = low_r + dig_hi;
      end
      POS_ADDR_0: begin
        low_nxt   = low_sum;
        res.valid = 1'b1;
        res.value = low_sum;
        res.kind  = KIND_ADDRESS;
      end
      default: begin
      end
    endcase

    // data words, low byte first
    if (pos > POS_TYPE_END && pos < end_r) begin
      case (pos[1:0])
        PH_LOW_HI: low_nxt = dig_hi;
        PH_LOW_LO: low_nxt = low_sum;
        PH_HIGH_HI: high_nxt = dig_hi;
        PH_HIGH_LO: begin
          high_nxt  = {high_sum[7:0], 8'h00};
          low_nxt   = low_r + {high_sum[7:0], 8'h00};
          res.valid = 1'b1;
          res.value = low_r + {high_sum[7:0], 8'h00};
          res.kind  = KIND_DATA;
        end
        default: begin
        end
      endcase
    end

    pos_nxt = pos + 16'd1;

    // ring slot advances on every emitted word
    if (res.valid) begin
      slot_nxt = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    end else begin
      slot_nxt = slot_r;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      end_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
      slot_r <= '0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      end_r  <= end_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      slot_r <= slot_nxt;
    end
  end

  // checks
  `HRCP_ASSERT_NEXT(a_colon_restart, advance && is_colon, pos_r == POS_LEN_HI, "colon did not restart position")
  `HRCP_ASSERT_NEXT(a_slot_step, advance && res.valid, slot_r == (($past(slot_r) == SLOT_W'(RING_DEPTH - 1)) ? '0 : $past(slot_r) + 1'b1), "slot did not advance")
  `HRCP_ASSERT_NEXT(a_slot_hold, advance && !res.valid, $stable(slot_r), "slot moved without a word")
  `HRCP_ASSERT_SAME(a_len_pos, res.valid && res.kind == KIND_LENGTH, pos == POS_LEN_LO, "length word off position")

endmodule

`default_nettype wire

### hdl/hrcp_out_stage.sv
`default_nettype none

module hrcp_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire hrcp_pkg::res_t res,
  output logic                out_free,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [23:0]         out_tdata,  // [4:0] slot, [20:5] word_value, [23:21] zero
  output logic [1:0]          out_tuser   // [1:0] word_kind
);
  import hrcp_pkg::*;

  logic        valid_r;
  logic [4:0]  slot_r;
  logic [15:0] value_r;
  word_kind_t  kind_r;

  // result register frees when empty or taken this cycle
  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, value_r, slot_r};
  assign out_tuser  = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res.valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      slot_r  <= res.slot;
      value_r <= res.value;
      kind_r  <= res.kind;
    end
  end

endmodule

`default_nettype wire

### hdl/hex_record_char_parser.sv
// path: a character is held in the input register, decoded, and its word is
// registered in the result register before it reaches the output
// throughput: one character per cycle while the result register is free, with
// a single decode pass between the input register and the result register
// reset: rst_n synchronous active low, clears position, accumulators,
// record end, ring slot and both valid flags
`default_nettype none

module hex_record_char_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [4:0] slot, [20:5] word_value, [23:21] zero
  output logic [1:0]       out_tuser   // [1:0] word_kind
);
  import hrcp_pkg::*;

  logic       advance;
  logic       item_valid;
  logic [7:0] item_char;
  logic       out_free;
  res_t       res;

  hrcp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item_char  (item_char)
  );

  hrcp_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_char  (item_char),
    .out_free   (out_free),
    .advance    (advance),
    .res        (res)
  );

  hrcp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
